/* design/cecla_pkg.sv */
// ----------------------------------------------------------------------------
// cecla_pkg
// Shared types, operation codes and the candidate address table for the
// CEC logical address pool.
// ----------------------------------------------------------------------------
package cecla_pkg;

    // Operation codes of one request item
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    // CEC device type codes
    localparam logic [2:0] DEV_TV       = 3'd0;
    localparam logic [2:0] DEV_RECORDER = 3'd1;
    localparam logic [2:0] DEV_TUNER    = 3'd3;
    localparam logic [2:0] DEV_PLAYBACK = 3'd4;
    localparam logic [2:0] DEV_AUDIO    = 3'd5;

    // Broadcast / unregistered address, also the "no grant" value
    localparam logic [3:0] ADDR_NONE = 4'd15;

    localparam int NUM_CAND = 4;

    // Request item
    typedef struct packed {
        op_t        op;
        logic [2:0] dev_kind;
        logic [3:0] release_address;
    } req_t;

    // Result item
    typedef struct packed {
        logic [3:0] grant_addr;
        logic       found;
    } rsp_t;

    // Candidate list for one device type
    typedef struct packed {
        logic [2:0]                count;
        logic [NUM_CAND-1:0][3:0]  addr;
    } cand_t;

    // Outcome of the candidate search
    typedef struct packed {
        logic [3:0] addr;
        logic       found;
    } pick_t;

    // Candidate addresses per device type, checked from addr[0] upwards
    function automatic cand_t cand_lookup(input logic [2:0] dev_kind);
        cand_t c;
        c.addr = '0;
        case (dev_kind)
            DEV_TV:
            begin
                c.count   = 3'd2;
                c.addr[0] = 4'd0;
                c.addr[1] = 4'd14;
            end
            DEV_RECORDER:
            begin
                c.count   = 3'd3;
                c.addr[0] = 4'd1;
                c.addr[1] = 4'd2;
                c.addr[2] = 4'd9;
            end
            DEV_TUNER:
            begin
                c.count   = 3'd4;
                c.addr[0] = 4'd3;
                c.addr[1] = 4'd6;
                c.addr[2] = 4'd7;
                c.addr[3] = 4'd10;
            end
            DEV_PLAYBACK:
            begin
                c.count   = 3'd3;
                c.addr[0] = 4'd4;
                c.addr[1] = 4'd8;
                c.addr[2] = 4'd11;
            end
            DEV_AUDIO:
            begin
                c.count   = 3'd1;
                c.addr[0] = 4'd5;
            end
            default:
            begin
                c.count   = 3'd1;
                c.addr[0] = ADDR_NONE;
            end
        endcase
        return c;
    endfunction

endpackage

/* design/cecla_alloc.sv */
// ----------------------------------------------------------------------------
// cecla_alloc
// Decodes one request item against the current address map: picks the first
// free candidate for an allocate, and works out the next map value.
// ----------------------------------------------------------------------------
module cecla_alloc (
    input  cecla_pkg::req_t  item,
    input  logic [15:0]      used_map,
    output cecla_pkg::pick_t pick,
    output logic [15:0]      map_next
);

    cecla_pkg::cand_t cand;

    // Look up the candidate list of the requested type
    assign cand = cecla_pkg::cand_lookup(item.dev_kind);

    // Priority pick over the candidates, then update the map
    always_comb
    begin
        pick.addr  = cecla_pkg::ADDR_NONE;
        pick.found = 1'b0;
        map_next   = used_map;
        case (item.op)
            cecla_pkg::OP_ALLOC:
            begin
                // scan from the last candidate so the earliest free one wins
                for (int i = cecla_pkg::NUM_CAND - 1; i >= 0; i--)
                begin
                    if ((3'(i) < cand.count) && !used_map[cand.addr[i]])
                    begin
                        pick.addr  = cand.addr[i];
                        pick.found = 1'b1;
                    end
                end
                if (pick.found)
                begin
                    map_next[pick.addr] = 1'b1;
                end
            end
            cecla_pkg::OP_RELEASE:
            begin
                map_next[item.release_address] = 1'b0;
            end
            cecla_pkg::OP_CLEAR:
            begin
                map_next = '0;
            end
            default:
            begin
                // undefined op: no change
                map_next = used_map;
            end
        endcase
    end

endmodule

/* design/cec_logical_address_pool.sv */
// ----------------------------------------------------------------------------
// cec_logical_address_pool
// Keeps the map of HDMI-CEC logical addresses in use. An accepted request sits
// in the input register; the result register loads when that item moves on.
// Throughput: one item per cycle while the result is not stalled, set by the
// single map register that each item reads and updates in one pass. Reset
// clears the address map (all free) and both valid flags at once.
// ----------------------------------------------------------------------------
module cec_logical_address_pool (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cecla_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cecla_pkg::rsp_t rsp
);

    logic             s1_valid_reg;
    cecla_pkg::req_t  s1_item_reg;
    logic [15:0]      map_reg;
    logic [15:0]      map_next;
    logic             rsp_valid_reg;
    cecla_pkg::rsp_t  rsp_item_reg;
    cecla_pkg::pick_t pick;
    logic             s1_adv;
    logic             req_acc;

    // Move the held item on when the result register is free or being drained
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_adv;
    assign req_acc   = req_valid && !req_stall;

    cecla_alloc u_alloc (
        .item     (s1_item_reg),
        .used_map (map_reg),
        .pick     (pick),
        .map_next (map_next)
    );

    // Hold control state: valids and the address map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            map_reg       <= '0;
        end
        else
        begin
            if (req_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
                map_reg       <= map_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_item_reg <= req;
        end
        if (s1_adv)
        begin
            rsp_item_reg.grant_addr <= pick.addr;
            rsp_item_reg.found      <= pick.found;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

    // A clear that goes through leaves an empty map
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_item_reg.op == cecla_pkg::OP_CLEAR)) |=> (map_reg == '0))
        else $error("map not empty after clear");

    // A granted address is marked used in the next map
    a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && pick.found) |=> map_reg[$past(pick.addr)])
        else $error("granted address not marked used");

    // A grant only ever takes an address that was free
    a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && pick.found) |-> !map_reg[pick.addr])
        else $error("grant of an address already in use");

    // The map only moves when an item goes through
    a_map_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(map_reg))
        else $error("map changed with no item");

    // A result without a grant carries the none address
    a_none_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_item_reg.found)
            |-> (rsp_item_reg.grant_addr == cecla_pkg::ADDR_NONE))
        else $error("failed result with an address other than none");

endmodule
